// ===== src/sobel_edge_magnitude_top_macros.svh =====
`ifndef SOBEL_EDGE_MAGNITUDE_TOP_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_TOP_MACROS_SVH

// same-cycle implication
`define SEM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SEM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sem_pkg.sv =====
package sem_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned SampW  = 8;
  localparam int unsigned NumCh  = 4;
  localparam int unsigned OutColW = 10;
  localparam int unsigned RowW   = 16;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] RegImageWidth   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegImageHeight  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegChannelCount = 2'd2;

  typedef logic [WordW-1:0] word_t;
  typedef word_t [8:0] win_t;
  // column-major neighborhood: [col][row]
  typedef word_t [2:0][2:0] nbhd_t;

endpackage

// ===== src/sem_ram.sv =====
module sem_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/sem_kernel.sv =====
module sem_kernel (
  input  sem_pkg::nbhd_t nbhd_i,
  input  logic [2:0]     nch_i,
  output logic [7:0]     edge_o
);
  import sem_pkg::*;

  always_comb begin
    logic signed [11:0] p [3][3];
    logic signed [11:0] gx;
    logic signed [11:0] gy;
    logic [10:0]        ax;
    logic [10:0]        ay;
    logic [11:0]        s;
    logic [9:0]         v;
    logic [9:0]         acc;
    acc = '0;
    for (int ch = 0; ch < NumCh; ch++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          p[i][j] = signed'({4'b0, nbhd_i[i][j][ch*SampW +: SampW]});
        end
      end
      gx = (p[2][0] + (p[2][1] <<< 1) + p[2][2]) - (p[0][0] + (p[0][1] <<< 1) + p[0][2]);
      gy = (p[0][2] + (p[1][2] <<< 1) + p[2][2]) - (p[0][0] + (p[1][0] <<< 1) + p[2][0]);
      ax = gx[11] ? 11'(-gx) : gx[10:0];
      ay = gy[11] ? 11'(-gy) : gy[10:0];
      s  = {1'b0, ax} + {1'b0, ay};
      v  = s[11:2];
      if (v > 10'd255) begin
        v = 10'd255;
      end
      if (3'(ch) < nch_i) begin
        acc = acc + v;
      end
    end
    edge_o = (acc > 10'd255) ? 8'd255 : acc[7:0];
  end

endmodule

// ===== src/sobel_edge_magnitude_top.sv =====
// Streaming 3x3 Sobel edge magnitude over pixels of up to four 8-bit channels.
// Input channel: in_valid_i/in_ready_o with sample_0_i..sample_3_i, one pixel
// per item in raster order. Output channel: out_valid_o/out_ready_i with
// edge_value_o, out_col_o, out_row_o and last_of_run_o; one input item gives
// zero to four results, the final one flagged by last_of_run_o.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i (0 width,
// 1 height, 2 channel count); write only while the block is idle.
// An accepted item passes the read stage, the emission stage and the output
// register. Throughput: one item per cycle while each item gives at most one
// result and the receiver accepts; an item with more results holds the
// emission stage, as the output register loads one result per cycle.
// Two line-store RAMs (one read port each, registered read) hold the previous
// rows; a same-address bypass covers back-to-back items at width one.
// Reset clears counters, the window and all valid state and loads the
// default configuration; line stores are not cleared.
// When the receiver stalls, the output register holds, the emission stage
// holds, and in_ready_o drops once the read stage is also full.
module sobel_edge_magnitude_top #(
  parameter int unsigned MAX_WIDTH    = 1024,
  parameter int unsigned MAX_CHANNELS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sem_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sem_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    sample_0_i,
  input  logic [7:0]                    sample_1_i,
  input  logic [7:0]                    sample_2_i,
  input  logic [7:0]                    sample_3_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    edge_value_o,
  output logic [sem_pkg::OutColW-1:0]   out_col_o,
  output logic [sem_pkg::RowW-1:0]      out_row_o,
  output logic                          last_of_run_o
);
  import sem_pkg::*;

  localparam int unsigned XW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CW = (WW > 11) ? WW : 11;

  logic [10:0]     image_width_q;
  logic [RowW-1:0] image_height_q;
  logic [2:0]      channel_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q   <= 11'd640;
      image_height_q  <= 16'd480;
      channel_count_q <= 3'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegImageWidth:   image_width_q   <= cfg_data_i[10:0];
        RegImageHeight:  image_height_q  <= cfg_data_i;
        RegChannelCount: channel_count_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0]   w_ext;
  logic [CW-1:0]   w_eff;
  logic [XW-1:0]   wm1;
  logic [RowW-1:0] hm1;
  logic [2:0]      nch;

  always_comb begin
    w_ext = CW'(image_width_q);
    if (w_ext == '0) begin
      w_eff = CW'(1);
    end else if (w_ext > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    wm1 = XW'(w_eff - CW'(1));
    hm1 = (image_height_q == '0) ? '0 : image_height_q - 16'd1;
    if (channel_count_q == '0) begin
      nch = 3'd1;
    end else if (channel_count_q > 3'(MAX_CHANNELS)) begin
      nch = 3'(MAX_CHANNELS);
    end else begin
      nch = channel_count_q;
    end
  end

  // input acceptance and position counters
  logic            in_acc;
  logic [XW-1:0]   col_q;
  logic [RowW-1:0] row_q;
  logic            endcol0;
  logic            endrow0;

  assign in_acc  = in_valid_i && in_ready_o;
  assign endcol0 = col_q >= wm1;
  assign endrow0 = row_q >= hm1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      if (endcol0) begin
        col_q <= '0;
        row_q <= endrow0 ? '0 : row_q + 16'd1;
      end else begin
        col_q <= col_q + XW'(1);
      end
    end
  end

  // stage A: line-store read
  logic            a_valid_q;
  logic [XW-1:0]   a_x_q;
  logic [RowW-1:0] a_y_q;
  logic [XW-1:0]   a_wm1_q;
  logic            a_endcol_q;
  logic            a_endrow_q;
  word_t           a_cur_q;
  logic            fwd_q;
  word_t           fwd_up_q;
  word_t           fwd_mid_q;
  word_t           up_rd;
  word_t           mid_rd;
  word_t           a_up;
  word_t           a_mid;
  logic            a_move;

  assign a_up  = fwd_q ? fwd_up_q  : up_rd;
  assign a_mid = fwd_q ? fwd_mid_q : mid_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      fwd_q     <= 1'b0;
    end else if (in_acc) begin
      a_valid_q <= 1'b1;
      fwd_q     <= a_move && (a_x_q == col_q);
    end else if (a_move) begin
      a_valid_q <= 1'b0;
      fwd_q     <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_x_q      <= col_q;
      a_y_q      <= row_q;
      a_wm1_q    <= wm1;
      a_endcol_q <= endcol0;
      a_endrow_q <= endrow0;
      a_cur_q    <= {sample_3_i, sample_2_i, sample_1_i, sample_0_i};
      fwd_up_q   <= a_mid;
      fwd_mid_q  <= a_cur_q;
    end
  end

  sem_ram #(.Width(WordW), .Depth(MAX_WIDTH)) u_upper (
    .clk_i   (clk_i),
    .we_i    (a_move),
    .waddr_i (a_x_q),
    .wdata_i (a_mid),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (up_rd)
  );

  sem_ram #(.Width(WordW), .Depth(MAX_WIDTH)) u_middle (
    .clk_i   (clk_i),
    .we_i    (a_move),
    .waddr_i (a_x_q),
    .wdata_i (a_cur_q),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (mid_rd)
  );

  // stage B: window and result emission
  win_t            window_q;
  logic [3:0]      b_mask_q;
  logic            b_x1_q;
  logic            b_x2_q;
  logic            b_y1_q;
  logic            b_y2_q;
  logic [XW-1:0]   b_xm1_q;
  logic [XW-1:0]   b_wm1_q;
  logic [RowW-1:0] b_y_q;
  logic [RowW-1:0] b_ym1_q;
  logic [3:0]      sel_oh;
  logic [3:0]      rest;
  logic            b_emit;
  logic            b_last;
  logic            a_x1;
  logic            a_y1;

  assign sel_oh = b_mask_q & (~b_mask_q + 4'd1);
  assign rest   = b_mask_q & ~sel_oh;
  assign b_last = (rest == '0);
  assign b_emit = (b_mask_q != '0) && (!out_valid_o || out_ready_i);
  assign a_move = a_valid_q && ((b_mask_q == '0) || (b_emit && b_last));
  assign in_ready_o = !a_valid_q || a_move;
  assign a_x1 = a_x_q != '0;
  assign a_y1 = a_y_q != '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      b_mask_q <= '0;
    end else if (a_move) begin
      window_q[2:0] <= window_q[5:3];
      window_q[5:3] <= window_q[8:6];
      window_q[6]   <= a_up;
      window_q[7]   <= a_mid;
      window_q[8]   <= a_cur_q;
      b_mask_q      <= {a_endrow_q && a_endcol_q, a_endrow_q && a_x1,
                        a_y1 && a_endcol_q, a_y1 && a_x1};
    end else if (b_emit) begin
      b_mask_q <= rest;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_move) begin
      b_x1_q  <= a_x1;
      b_x2_q  <= a_x_q >= XW'(2);
      b_y1_q  <= a_y1;
      b_y2_q  <= a_y_q >= 16'd2;
      b_xm1_q <= a_x_q - XW'(1);
      b_wm1_q <= a_wm1_q;
      b_y_q   <= a_y_q;
      b_ym1_q <= a_y_q - 16'd1;
    end
  end

  logic       sel_b;
  logic       sel_c;
  logic [1:0] ci [3];
  logic [1:0] ri [3];
  nbhd_t      nbhd;
  logic [7:0] edge_val;

  assign sel_b = sel_oh[1] || sel_oh[3];
  assign sel_c = sel_oh[2] || sel_oh[3];

  always_comb begin
    ci[0] = sel_b ? (b_x1_q ? 2'd1 : 2'd2) : (b_x2_q ? 2'd0 : 2'd1);
    ci[1] = sel_b ? 2'd2 : 2'd1;
    ci[2] = 2'd2;
    ri[0] = sel_c ? (b_y1_q ? 2'd1 : 2'd2) : (b_y2_q ? 2'd0 : 2'd1);
    ri[1] = sel_c ? 2'd2 : 2'd1;
    ri[2] = 2'd2;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        nbhd[i][j] = window_q[4'(ci[i]) * 4'd3 + 4'(ri[j])];
      end
    end
  end

  sem_kernel u_kernel (
    .nbhd_i (nbhd),
    .nch_i  (nch),
    .edge_o (edge_val)
  );

  // output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (b_emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_emit) begin
      edge_value_o  <= edge_val;
      out_col_o     <= OutColW'(sel_b ? b_wm1_q : b_xm1_q);
      out_row_o     <= sel_c ? b_y_q : b_ym1_q;
      last_of_run_o <= b_last;
    end
  end

  assign out_valid_o = out_valid_q;

  `include "sobel_edge_magnitude_top_macros.svh"

  `SEM_ASSERT_NXT(a_mask_hold, (b_mask_q != '0) && out_valid_q && !out_ready_i, $stable(b_mask_q), "emission advanced during output stall")
  `SEM_ASSERT_IMP(a_move_last, a_move, (b_mask_q == '0) || $onehot(b_mask_q), "stage A moved while results pending")
  `SEM_ASSERT_IMP(a_fwd_valid, fwd_q, a_valid_q, "bypass set without item in read stage")

endmodule
